FILE: rtl/core/gap_tolerant_event_aggregator_unit_assert.svh
// assertion macros for the event aggregator
`ifndef GAP_TOLERANT_EVENT_AGGREGATOR_UNIT_ASSERT_SVH
`define GAP_TOLERANT_EVENT_AGGREGATOR_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define GTEA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gtea assertion failed");

// next-cycle implication, checked during reset as well
`define GTEA_ASSERT_AFTER(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("gtea assertion failed");

`endif

FILE: rtl/core/gtea_pkg.sv
// shared types and constants of the event aggregator
package gtea_pkg;

    localparam int HIT_BITS   = 16;
    localparam int CLASS_W    = 8;
    localparam int TIME_W     = 32;
    localparam int GAP_W      = 9;
    localparam int MAX_GAP_W  = 8;
    localparam int MIN_HITS_W = 16;
    localparam int HIT_OUT_W  = 16;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 152;

    localparam logic [HIT_BITS-1:0]   HIT_MAX = '1;
    localparam logic [CNT_W-1:0]      CNT_MAX = '1;
    localparam logic [GAP_W-1:0]      GAP_LIMIT = GAP_W'(256);
    localparam logic [CLASS_W-1:0]    TARGET_CLASS_RST = '0;
    localparam logic [MAX_GAP_W-1:0]  MAX_GAP_RST = MAX_GAP_W'(2);
    localparam logic [MIN_HITS_W-1:0] MIN_HITS_RST = MIN_HITS_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_CLASS = 2'd0,
        CFG_MAX_GAP      = 2'd1,
        CFG_MIN_HITS     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_WINDOW = 1'b0,
        CMD_FLUSH  = 1'b1
    } cmd_t;

    // request held in the input register
    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic [CLASS_W-1:0] class_label;
        logic [TIME_W-1:0]  time_ms;
    } item_t;

    // one reported event
    typedef struct packed {
        logic [CLASS_W-1:0]   event_class_out;
        logic [TIME_W-1:0]    first_hit_ms;
        logic [TIME_W-1:0]    end_ms;
        logic [HIT_OUT_W-1:0] hit_total;
        logic [CNT_W-1:0]     events_reported;
        logic [CNT_W-1:0]     windows_seen;
    } result_t;

    // event tracker status, watched by the assertions
    typedef struct packed {
        logic                evt_open;
        logic [GAP_W-1:0]    gap_count;
        logic [HIT_BITS-1:0] hit_count;
    } status_t;

endpackage

FILE: rtl/core/gtea_in_reg.sv
// input register stage of the event aggregator
module gtea_in_reg
    import gtea_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               cmd,
    input  logic [CLASS_W-1:0] class_label,
    input  logic [TIME_W-1:0]  time_ms,
    input  logic               advance,
    output item_t              item
);

    logic               valid_reg;
    logic               cmd_reg;
    logic [CLASS_W-1:0] class_reg;
    logic [TIME_W-1:0]  time_reg;

    // free when empty or when the held request moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg   <= cmd;
            class_reg <= class_label;
            time_reg  <= time_ms;
        end
    end

    assign item = '{valid: valid_reg, cmd: cmd_reg, class_label: class_reg,
                    time_ms: time_reg};

endmodule

FILE: rtl/core/gtea_core.sv
// event tracking state, configuration registers and result register
module gtea_core
    import gtea_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  item_t                 item,
    output logic                  advance,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               result,
    output status_t               status
);

    logic [CLASS_W-1:0]    target_class_reg;
    logic [MAX_GAP_W-1:0]  max_gap_reg;
    logic [MIN_HITS_W-1:0] min_hits_reg;

    logic                evt_open_reg,  evt_open_next;
    logic [GAP_W-1:0]    gap_count_reg, gap_count_next;
    logic [HIT_BITS-1:0] hit_count_reg, hit_count_next;
    logic [TIME_W-1:0]   start_reg,     start_next;
    logic [TIME_W-1:0]   last_hit_reg,  last_hit_next;
    logic [CNT_W-1:0]    event_cnt_reg, event_cnt_next;
    logic [CNT_W-1:0]    window_cnt_reg, window_cnt_next;

    logic    m_valid_reg;
    result_t result_reg, result_next;
    logic    report;

    logic                close_event;
    logic [GAP_W-1:0]    gap_inc;
    logic [HIT_BITS-1:0] hit_base;

    // the held request moves on when the result register is free or drains
    assign advance = item.valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_class_reg <= TARGET_CLASS_RST;
            max_gap_reg      <= MAX_GAP_RST;
            min_hits_reg     <= MIN_HITS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TARGET_CLASS: target_class_reg <= cfg_data[CLASS_W-1:0];
                CFG_MAX_GAP:      max_gap_reg      <= cfg_data[MAX_GAP_W-1:0];
                CFG_MIN_HITS:     min_hits_reg     <= cfg_data[MIN_HITS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        evt_open_next   = evt_open_reg;
        gap_count_next  = gap_count_reg;
        hit_count_next  = hit_count_reg;
        start_next      = start_reg;
        last_hit_next   = last_hit_reg;
        event_cnt_next  = event_cnt_reg;
        window_cnt_next = window_cnt_reg;
        close_event     = 1'b0;
        report          = 1'b0;
        gap_inc         = gap_count_reg + GAP_W'(1);
        hit_base        = hit_count_reg;

        if (advance) begin
            if (item.cmd == CMD_FLUSH) begin
                close_event = evt_open_reg;
            end else begin
                window_cnt_next = window_cnt_reg + CNT_W'(1);
                if (item.class_label != target_class_reg) begin
                    if (evt_open_reg) begin
                        gap_count_next = gap_inc;
                        close_event    = gap_inc > GAP_W'(max_gap_reg);
                    end
                end else begin
                    if (!evt_open_reg) begin
                        evt_open_next = 1'b1;
                        start_next    = item.time_ms;
                        hit_base      = '0;
                    end
                    hit_count_next = (hit_base < HIT_MAX) ? hit_base + HIT_BITS'(1)
                                                          : hit_base;
                    gap_count_next = '0;
                    last_hit_next  = item.time_ms;
                end
            end

            if (close_event) begin
                evt_open_next  = 1'b0;
                hit_count_next = '0;
                gap_count_next = '0;
                if (CNT_W'(hit_count_reg) >= CNT_W'(min_hits_reg)) begin
                    report = 1'b1;
                    if (event_cnt_reg != CNT_MAX) begin
                        event_cnt_next = event_cnt_reg + CNT_W'(1);
                    end
                end
            end
        end

        result_next = '{event_class_out: target_class_reg,
                        first_hit_ms:    start_reg,
                        end_ms:          last_hit_reg,
                        hit_total:       HIT_OUT_W'(hit_count_reg),
                        events_reported: event_cnt_next,
                        windows_seen:    window_cnt_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evt_open_reg   <= 1'b0;
            gap_count_reg  <= '0;
            hit_count_reg  <= '0;
            start_reg      <= '0;
            last_hit_reg   <= '0;
            event_cnt_reg  <= '0;
            window_cnt_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            evt_open_reg   <= evt_open_next;
            gap_count_reg  <= gap_count_next;
            hit_count_reg  <= hit_count_next;
            start_reg      <= start_next;
            last_hit_reg   <= last_hit_next;
            event_cnt_reg  <= event_cnt_next;
            window_cnt_reg <= window_cnt_next;
            if (advance) begin
                m_valid_reg <= report;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && report) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;
    assign status  = '{evt_open: evt_open_reg, gap_count: gap_count_reg,
                       hit_count: hit_count_reg};

endmodule

FILE: rtl/core/gap_tolerant_event_aggregator_unit.sv
// Gap-tolerant event aggregator: top level.
//
// The s_ channel takes one request per classified window (tuser = 0) or a
// flush (tuser = 1). Windows of the target class open or extend an event;
// other windows inside an event count as gap windows, and once more than
// max_gap of them follow the last hit the event closes. A flush closes any
// open event. A closed event with at least min_hits hits comes out on the
// m_ channel as one result; all other requests give no result.
// The cfg_ channel writes target_class (index 0), max_gap (1) and min_hits
// (2); the user must write them only while the block is idle, which the
// block does not enforce. Other indexes are dropped. cfg_ready is always high.
// A request accepted into the input register is decided as it moves on into
// the event state, and a result is registered into the result register that
// drives m_tvalid. Throughput is one request per cycle while the receiver
// keeps up, set by the single event state update between the two registers.
// When the receiver stalls, the input register still takes one more request
// and s_tready drops only while both the input and result registers are full.
// Reset clears the event state, both counters and both valid flags, and
// restores the register defaults (class 0, max gap 2, min hits 3).
`include "gap_tolerant_event_aggregator_unit_assert.svh"

module gap_tolerant_event_aggregator_unit
    import gtea_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // window request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // class_label[7:0], time_ms[39:8]
    input  logic                  s_tuser,   // cmd[0]
    // event result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // event_class_out[7:0], first hit time[39:8], end_ms[71:40], hit_total[87:72],
    // events_reported[119:88], windows_seen[151:120]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    item_t   item;
    logic    advance;
    result_t result;
    status_t status;
    logic    tracker_clear;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // input register: holds one request while the result side is stalled
    gtea_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .cmd         (s_tuser),
        .class_label (s_tdata[CLASS_W-1:0]),
        .time_ms     (s_tdata[CLASS_W +: TIME_W]),
        .advance     (advance),
        .item        (item)
    );

    // event state update and result register
    gtea_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .advance   (advance),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .result    (result),
        .status    (status)
    );

    // result fields packed from the lowest bit up
    assign m_tdata = {result.windows_seen, result.events_reported, result.hit_total,
                      result.end_ms, result.first_hit_ms, result.event_class_out};

    // gap and hit counts both back at zero
    assign tracker_clear = (status.gap_count == '0) && (status.hit_count == '0);

    // no event open means nothing left over from the last one
    `GTEA_ASSERT_IMP(a_idle_clear, aclk, aresetn, !status.evt_open, tracker_clear)
    // an open event always holds at least its opening hit
    `GTEA_ASSERT_IMP(a_open_has_hit, aclk, aresetn, status.evt_open, status.hit_count != '0)
    // a reported event is always counted
    `GTEA_ASSERT_IMP(a_report_counted, aclk, aresetn, m_tvalid, result.events_reported != '0)
    // reset leaves both registers empty
    `GTEA_ASSERT_AFTER(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the gap-tolerant event aggregator
module tb_top;
    import gtea_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: slowest legal run is well under a fifth of this
    localparam int CYCLE_LIMIT = 600_000;
    // latency of the block plus margin, used before config writes and at the end
    localparam int SETTLE_CYCLES = 6;
    // long receiver hold-off that lets the block fill up and stall its input
    localparam int LONG_HOLD = 400;
    // register index that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // how a directed row gets its expectation
    typedef enum logic [1:0] {
        ROW_PREDICT,   // whatever the event tracker model says
        ROW_NO_EVENT,  // no report may come out of this request
        ROW_TYPED      // report written out in the table
    } row_check_t;

    typedef struct {
        cmd_t               cmd;
        logic [CLASS_W-1:0] cls;
        logic [TIME_W-1:0]  t;
        row_check_t         chk;
        result_t            ev;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gap_tolerant_event_aggregator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // event tracker model: registers and state as the block holds them
    // ------------------------------------------------------------------
    logic [CLASS_W-1:0]    tgt_class;
    logic [MAX_GAP_W-1:0]  gap_allow;
    logic [MIN_HITS_W-1:0] hits_needed;

    logic                  open_evt;
    logic [GAP_W-1:0]      gaps_run;
    logic [HIT_BITS-1:0]   hit_run;
    logic [TIME_W-1:0]     evt_first_ms;
    logic [TIME_W-1:0]     evt_last_ms;
    logic [CNT_W-1:0]      reported_cnt;
    logic [CNT_W-1:0]      window_cnt;

    // reports still owed by the block, oldest first
    result_t pending_events[$];

    int  errors = 0;
    int  items_sent = 0;
    int  cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  hold_request = 1'b0;

    // directed requests from reset defaults (class 0, max gap 2, min hits 3)
    stim_row_t dir_rows [0:20] = '{
        // flush with nothing open: no report
        '{CMD_FLUSH,  8'd0,   32'd0,         ROW_NO_EVENT, '0},
        // event opens, time extremes on the hits
        '{CMD_WINDOW, 8'd0,   32'd100,       ROW_NO_EVENT, '0},
        '{CMD_WINDOW, 8'd0,   32'd0,         ROW_NO_EVENT, '0},
        '{CMD_WINDOW, 8'd0,   32'hFFFF_FFFF, ROW_NO_EVENT, '0},
        // gap windows, class extreme among them; third one closes the event
        '{CMD_WINDOW, 8'd5,   32'h5555_5555, ROW_NO_EVENT, '0},
        '{CMD_WINDOW, 8'd255, 32'hAAAA_AAAA, ROW_NO_EVENT, '0},
        '{CMD_WINDOW, 8'd1,   32'd3,
          ROW_TYPED, result_t'{8'd0, 32'd100, 32'hFFFF_FFFF, 16'd3, 32'd1, 32'd6}},
        // short event dropped on flush
        '{CMD_WINDOW, 8'd0,   32'd7,         ROW_PREDICT,  '0},
        '{CMD_FLUSH,  8'd0,   32'd0,         ROW_NO_EVENT, '0},
        '{CMD_FLUSH,  8'd255, 32'hFFFF_FFFF, ROW_NO_EVENT, '0},
        // exactly min hits, closed by flush; flush does not count as a window
        '{CMD_WINDOW, 8'd0,   32'd8,         ROW_PREDICT,  '0},
        '{CMD_WINDOW, 8'd0,   32'd9,         ROW_PREDICT,  '0},
        '{CMD_WINDOW, 8'd0,   32'd10,        ROW_PREDICT,  '0},
        '{CMD_FLUSH,  8'd0,   32'd0,
          ROW_TYPED, result_t'{8'd0, 32'd8, 32'd10, 16'd3, 32'd2, 32'd10}},
        // gaps within tolerance, each hit clears the gap count
        '{CMD_WINDOW, 8'd0,   32'd20,        ROW_PREDICT,  '0},
        '{CMD_WINDOW, 8'd3,   32'd21,        ROW_PREDICT,  '0},
        '{CMD_WINDOW, 8'd0,   32'd22,        ROW_PREDICT,  '0},
        '{CMD_WINDOW, 8'd4,   32'd23,        ROW_PREDICT,  '0},
        '{CMD_WINDOW, 8'd4,   32'd24,        ROW_PREDICT,  '0},
        '{CMD_WINDOW, 8'd0,   32'd25,        ROW_PREDICT,  '0},
        '{CMD_FLUSH,  8'd0,   32'd0,
          ROW_TYPED, result_t'{8'd0, 32'd20, 32'd25, 16'd3, 32'd3, 32'd16}}
    };

    // close the open event, report it if it had enough hits
    function automatic bit close_tracked_event(output result_t ev);
        logic [HIT_BITS-1:0] hits;
        hits     = hit_run;
        open_evt = 1'b0;
        hit_run  = '0;
        gaps_run = '0;
        ev       = '0;
        if (CNT_W'(hits) < CNT_W'(hits_needed)) return 1'b0;
        if (reported_cnt != CNT_MAX) reported_cnt = reported_cnt + CNT_W'(1);
        ev.event_class_out = tgt_class;
        ev.first_hit_ms    = evt_first_ms;
        ev.end_ms          = evt_last_ms;
        ev.hit_total       = HIT_OUT_W'(hits);
        ev.events_reported = reported_cnt;
        ev.windows_seen    = window_cnt;
        return 1'b1;
    endfunction

    // advance the tracker by one request; returns 1 when a report is due
    function automatic bit track_request(input cmd_t cmd, input logic [CLASS_W-1:0] cls,
                                         input logic [TIME_W-1:0] t, output result_t ev);
        ev = '0;
        if (cmd == CMD_FLUSH) begin
            if (!open_evt) return 1'b0;
            return close_tracked_event(ev);
        end
        window_cnt = window_cnt + CNT_W'(1);
        if (cls != tgt_class) begin
            if (open_evt) begin
                gaps_run = gaps_run + GAP_W'(1);
                if (gaps_run > GAP_W'(gap_allow)) return close_tracked_event(ev);
            end
            return 1'b0;
        end
        if (!open_evt) begin
            open_evt     = 1'b1;
            evt_first_ms = t;
            hit_run      = '0;
        end
        if (hit_run != HIT_MAX) hit_run = hit_run + HIT_BITS'(1);
        gaps_run    = '0;
        evt_last_ms = t;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // offer one request, after a random gap if tx_idle_on is set, track it once accepted
    task automatic offer_request(input cmd_t cmd, input logic [CLASS_W-1:0] cls,
                                 input logic [TIME_W-1:0] t, input row_check_t chk,
                                 input result_t typed);
        int      gap;
        result_t ev;
        bit      due;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {t, cls};
        // inputs and outputs only move at rising edges, so the falling edge
        // shows what the next rising edge will see
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        items_sent++;
        due = track_request(cmd, cls, t, ev);
        case (chk)
            ROW_PREDICT: if (due) pending_events.push_back(ev);
            ROW_TYPED:   pending_events.push_back(typed);
            default: ;
        endcase
    endtask

    task automatic send_window(input logic [CLASS_W-1:0] cls, input logic [TIME_W-1:0] t);
        offer_request(CMD_WINDOW, cls, t, ROW_PREDICT, '0);
    endtask

    task automatic send_flush();
        offer_request(CMD_FLUSH, CLASS_W'($urandom), $urandom, ROW_PREDICT, '0);
    endtask

    // any class but the target
    function automatic logic [CLASS_W-1:0] miss_class();
        logic [CLASS_W-1:0] c;
        c = CLASS_W'($urandom);
        if (c == tgt_class) c = c + CLASS_W'(1);
        return c;
    endfunction

    // stop offering, wait until every report is in and the input register has drained
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        case (idx)
            CFG_TARGET_CLASS: tgt_class   = data[CLASS_W-1:0];
            CFG_MAX_GAP:      gap_allow   = data[MAX_GAP_W-1:0];
            CFG_MIN_HITS:     hits_needed = data[MIN_HITS_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed events with random content, some noise in between
    task automatic random_phase(input int quota);
        int goal;
        int hits;
        int gaps;
        int cap;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) begin
                cap  = (hits_needed < 6) ? int'(hits_needed) + 2 : 8;
                hits = $urandom_range(1, cap);
                for (int h = 0; h < hits; h++) begin
                    send_window(tgt_class, $urandom);
                    if (h != hits - 1) begin
                        // stay within tolerance between hits of one event
                        gaps = $urandom_range(0, (gap_allow < 3) ? int'(gap_allow) : 3);
                        repeat (gaps) send_window(miss_class(), $urandom);
                    end
                end
                if (gap_allow < 8 && $urandom_range(0, 1) == 1) begin
                    repeat (int'(gap_allow) + 1) send_window(miss_class(), $urandom);
                end else if ($urandom_range(0, 4) != 0) begin
                    send_flush();
                end
                // otherwise leave the event open into the next burst
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 4) == 0) send_flush();
                    else send_window(CLASS_W'($urandom), $urandom);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // report side
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    initial begin
        int      stall;
        result_t exp_ev;
        result_t got_ev;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            {got_ev.windows_seen, got_ev.events_reported, got_ev.hit_total,
             got_ev.end_ms, got_ev.first_hit_ms, got_ev.event_class_out} = m_tdata;
            if (pending_events.size() == 0) begin
                $display("%0t: report with nothing expected, got %h", $time, m_tdata);
                errors++;
            end else begin
                exp_ev = pending_events.pop_front();
                check_field("event_class_out", 32'(exp_ev.event_class_out),
                            32'(got_ev.event_class_out));
                check_field("first_hit_ms", exp_ev.first_hit_ms, got_ev.first_hit_ms);
                check_field("end_ms", exp_ev.end_ms, got_ev.end_ms);
                check_field("hit_total", 32'(exp_ev.hit_total), 32'(got_ev.hit_total));
                check_field("events_reported", exp_ev.events_reported,
                            got_ev.events_reported);
                check_field("windows_seen", exp_ev.windows_seen, got_ev.windows_seen);
            end
            @(posedge aclk);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_TARGET_CLASS;
        cfg_data  <= '0;

        tgt_class    = TARGET_CLASS_RST;
        gap_allow    = MAX_GAP_RST;
        hits_needed  = MIN_HITS_RST;
        open_evt     = 1'b0;
        gaps_run     = '0;
        hit_run      = '0;
        evt_first_ms = '0;
        evt_last_ms  = '0;
        reported_cnt = '0;
        window_cnt   = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table against reset defaults
        foreach (dir_rows[i])
            offer_request(dir_rows[i].cmd, dir_rows[i].cls, dir_rows[i].t,
                          dir_rows[i].chk, dir_rows[i].ev);

        // mid-range settings; upper data bits of the class write are dropped
        write_reg(CFG_TARGET_CLASS, {8'hA5, 8'h5A});
        write_reg(CFG_MAX_GAP, 16'd1);
        write_reg(CFG_MIN_HITS, 16'd2);
        random_phase(140);

        // extremes: top class, no gap tolerance, every event reported
        write_reg(CFG_TARGET_CLASS, 16'hFFFF);
        write_reg(CFG_MAX_GAP, 16'd0);
        write_reg(CFG_MIN_HITS, 16'd0);
        // receiver holds off while hit/miss pairs keep producing reports
        tx_idle_on   = 1'b0;
        hold_request = 1'b1;
        repeat (20) begin
            send_window(tgt_class, $urandom);
            send_window(miss_class(), $urandom);
        end
        random_phase(120);

        // widest gap tolerance: 255 misses survive, the 256th closes
        write_reg(CFG_TARGET_CLASS, 16'd0);
        write_reg(CFG_MAX_GAP, 16'hFFFF);
        write_reg(CFG_MIN_HITS, 16'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        send_window(tgt_class, $urandom);
        repeat (255) send_window(miss_class(), $urandom);
        send_window(tgt_class, $urandom);
        repeat (256) send_window(miss_class(), $urandom);
        random_phase(90);

        // write to an index the block does not decode, then new settings
        write_reg(CFG_UNUSED, 16'($urandom));
        write_reg(CFG_TARGET_CLASS, 16'h0033);
        write_reg(CFG_MAX_GAP, 16'd3);
        write_reg(CFG_MIN_HITS, 16'd4);
        random_phase(140);

        // top min hits: only events that never reach it, all dropped
        write_reg(CFG_TARGET_CLASS, 16'h0081);
        write_reg(CFG_MAX_GAP, 16'd2);
        write_reg(CFG_MIN_HITS, 16'hFFFF);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        random_phase(50);

        settle_block();
        if (errors == 0 && pending_events.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
